@@ rtl/frame_time_budget_governor_macros.svh @@
// ----------------------------------------------------------------------------
// Frame time budget governor assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_BUDGET_GOVERNOR_MACROS_SVH
`define FRAME_TIME_BUDGET_GOVERNOR_MACROS_SVH

// same-cycle implication
`define FTBG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FTBG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ftbg_pkg.sv @@
// ----------------------------------------------------------------------------
// ftbg_pkg
// Types, codes and constants of the frame time budget governor.
// ----------------------------------------------------------------------------
package ftbg_pkg;

	localparam int TIME_W   = 20;
	localparam int TARGET_W = 17;
	localparam int LEVEL_W  = 2;
	localparam int KIND_W   = 2;
	localparam int WEIGHT_W = 2;
	localparam int RUN_W    = 8;
	localparam int CFG_IDX_W = 1;

	// defaults for the top level parameters
	localparam int RING_DEPTH_DEF     = 32;
	localparam int RECOVER_FRAMES_DEF = 10;
	localparam int STALL_FRAMES_DEF   = 60;

	// item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_EOF   = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// levels; LVL_AUTO only appears in forced_level
	localparam logic [LEVEL_W-1:0] LVL_GREEN  = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_YELLOW = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_RED    = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL_AUTO   = 2'd3;

	// task weights
	localparam logic [WEIGHT_W-1:0] WT_CRITICAL = 2'd0;
	localparam logic [WEIGHT_W-1:0] WT_HEAVY    = 2'd1;
	localparam logic [WEIGHT_W-1:0] WT_LIGHT    = 2'd2;
	localparam logic [WEIGHT_W-1:0] WT_TRIVIAL  = 2'd3;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FORCED = 1'd1;

	localparam logic [TARGET_W-1:0] TARGET_RESET = 17'd16667;

	// admission headroom in us (one bit above time width)
	localparam logic [TIME_W:0] MARGIN_HEAVY   = 21'd5000;
	localparam logic [TIME_W:0] MARGIN_LIGHT   = 21'd2000;
	localparam logic [TIME_W:0] MARGIN_TRIVIAL = 21'd500;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [TIME_W-1:0]   time_us;
		logic                pending_work;
		logic [WEIGHT_W-1:0] task_weight;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               task_allowed;
		logic               watchdog_fired;
	} result_t;

endpackage

@@ rtl/ftbg_ring.sv @@
// ----------------------------------------------------------------------------
// ftbg_ring
// Frame time history RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ftbg_ring #(
	parameter int DEPTH = ftbg_pkg::RING_DEPTH_DEF,
	parameter int WIDTH = ftbg_pkg::TIME_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/ftbg_ctrl.sv @@
// ----------------------------------------------------------------------------
// ftbg_ctrl
// Governor state and per-item update: ring sum, auto level, watchdog,
// task admission.
// ----------------------------------------------------------------------------
`include "frame_time_budget_governor_macros.svh"

module ftbg_ctrl #(
	parameter int RING_DEPTH     = ftbg_pkg::RING_DEPTH_DEF,
	parameter int RECOVER_FRAMES = ftbg_pkg::RECOVER_FRAMES_DEF,
	parameter int STALL_FRAMES   = ftbg_pkg::STALL_FRAMES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  ftbg_pkg::item_t                  item,
	input  logic [ftbg_pkg::TIME_W-1:0]      old_time,
	input  logic [ftbg_pkg::TARGET_W-1:0]    target_frame_us,
	input  logic [ftbg_pkg::LEVEL_W-1:0]     forced_level,
	output logic [$clog2(RING_DEPTH)-1:0]    rd_addr,
	output logic                             wr_en,
	output logic [$clog2(RING_DEPTH)-1:0]    wr_addr,
	output logic [ftbg_pkg::TIME_W-1:0]      wr_data,
	output ftbg_pkg::result_t                result
);

	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = ftbg_pkg::TIME_W + SLOT_W + 1;
	localparam int BUD_W  = CNT_W + ftbg_pkg::TARGET_W;
	localparam int CMP_W  = ((SUM_W > BUD_W) ? SUM_W : BUD_W) + 3;
	localparam int RUN_W  = ftbg_pkg::RUN_W;
	localparam int TW     = ftbg_pkg::TIME_W;

	logic [SLOT_W-1:0]           slot_q, slot_d, slot_inc;
	logic [CNT_W-1:0]            count_q, count_d, count_new;
	logic [SUM_W-1:0]            sum_q, sum_d, sum_new;
	logic [ftbg_pkg::LEVEL_W-1:0] auto_q, auto_d, auto_upd, wanted, lvl_now;
	logic [RUN_W-1:0]            better_q, better_d, better_upd, better_inc;
	logic [RUN_W-1:0]            stall_q, stall_d, stall_inc;
	logic [BUD_W-1:0]            budget;
	logic [CMP_W-1:0]            sum_x, bud_x;
	logic                        full, is_auto, fired, allowed;
	logic [TW:0]                 target_x, time_x;

	assign slot_inc = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign full     = (count_q == CNT_W'(RING_DEPTH));
	assign is_auto  = (forced_level == ftbg_pkg::LVL_AUTO);

	// ring replacement and running sum
	always_comb begin
		sum_new   = (full ? sum_q - SUM_W'(old_time) : sum_q) + SUM_W'(item.time_us);
		count_new = full ? count_q : count_q + 1'b1;
		budget    = BUD_W'(count_new) * BUD_W'(target_frame_us);
		sum_x     = CMP_W'(sum_new);
		bud_x     = CMP_W'(budget);
	end

	// wanted level: ratio tests without division
	always_comb begin
		if (sum_x > bud_x) begin
			wanted = ftbg_pkg::LVL_RED;
		end else if ((sum_x << 2) + sum_x > (bud_x << 2)) begin
			wanted = ftbg_pkg::LVL_YELLOW;
		end else begin
			wanted = ftbg_pkg::LVL_GREEN;
		end
	end

	// rise at once, fall one step after a run of better frames
	always_comb begin
		better_inc = better_q + 1'b1;
		auto_upd   = auto_q;
		better_upd = '0;
		if (wanted > auto_q) begin
			auto_upd = wanted;
		end else if (wanted < auto_q) begin
			if (better_inc >= RUN_W'(RECOVER_FRAMES)) begin
				auto_upd = auto_q - 1'b1;
			end else begin
				better_upd = better_inc;
			end
		end
	end

	assign stall_inc = stall_q + 1'b1;
	assign target_x  = (TW+1)'(target_frame_us);
	assign time_x    = {1'b0, item.time_us};
	assign lvl_now   = is_auto ? auto_q : forced_level;

	always_comb begin
		slot_d   = slot_q;
		count_d  = count_q;
		sum_d    = sum_q;
		auto_d   = auto_q;
		better_d = better_q;
		stall_d  = stall_q;
		fired    = 1'b0;
		allowed  = 1'b0;
		wr_en    = 1'b0;
		case (item.kind)
			ftbg_pkg::KIND_EOF: begin
				wr_en   = step;
				slot_d  = slot_inc;
				count_d = count_new;
				sum_d   = sum_new;
				stall_d = '0;
				if (is_auto) begin
					auto_d   = auto_upd;
					better_d = better_upd;
					if (auto_upd != ftbg_pkg::LVL_GREEN && item.pending_work) begin
						if (stall_inc >= RUN_W'(STALL_FRAMES)) begin
							fired    = 1'b1;
							slot_d   = '0;
							count_d  = '0;
							sum_d    = '0;
							auto_d   = ftbg_pkg::LVL_GREEN;
							better_d = '0;
						end else begin
							stall_d = stall_inc;
						end
					end
				end
			end
			ftbg_pkg::KIND_QUERY: begin
				case (item.task_weight)
					ftbg_pkg::WT_CRITICAL: allowed = 1'b1;
					ftbg_pkg::WT_HEAVY: allowed = (lvl_now == ftbg_pkg::LVL_GREEN) &&
						(target_x >= time_x + ftbg_pkg::MARGIN_HEAVY);
					ftbg_pkg::WT_LIGHT: allowed = (lvl_now != ftbg_pkg::LVL_RED) &&
						(target_x >= time_x + ftbg_pkg::MARGIN_LIGHT);
					default: allowed = (lvl_now != ftbg_pkg::LVL_RED) &&
						(target_x >= time_x + ftbg_pkg::MARGIN_TRIVIAL);
				endcase
			end
			ftbg_pkg::KIND_CLEAR: begin
				slot_d   = '0;
				count_d  = '0;
				sum_d    = '0;
				auto_d   = ftbg_pkg::LVL_GREEN;
				better_d = '0;
			end
			default: begin
			end
		endcase
	end

	// next item's replaced slot, forwarded past the item in this step;
	// after a clear the next item has an empty ring and ignores the read
	assign rd_addr = (step && item.kind == ftbg_pkg::KIND_EOF) ? slot_inc : slot_q;
	assign wr_addr = slot_q;
	assign wr_data = item.time_us;

	assign result.level          = is_auto ? auto_d : forced_level;
	assign result.task_allowed   = allowed;
	assign result.watchdog_fired = fired;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			auto_q   <= ftbg_pkg::LVL_GREEN;
			better_q <= '0;
			stall_q  <= '0;
		end else if (step) begin
			slot_q   <= slot_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
			auto_q   <= auto_d;
			better_q <= better_d;
			stall_q  <= stall_d;
		end
	end

	`FTBG_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(RING_DEPTH), "fill count past ring depth")
	`FTBG_ASSERT_NEXT(a_clear_empties, step && item.kind == ftbg_pkg::KIND_CLEAR, count_q == '0 && sum_q == '0 && slot_q == '0, "clear left history behind")
	`FTBG_ASSERT_NOW(a_fire_auto_only, step && fired, is_auto && item.kind == ftbg_pkg::KIND_EOF, "watchdog fired outside automatic end of frame")

endmodule

@@ rtl/frame_time_budget_governor.sv @@
// ----------------------------------------------------------------------------
// frame_time_budget_governor
// Frame time budget governor: history ring, green/yellow/red level, stall
// watchdog and task admission behind valid/ready channels.
// ----------------------------------------------------------------------------
// An accepted word waits in the work stage, then moves to the output register.
// Throughput: one word per cycle unless stalled; the ring RAM read is issued at
//   accept, and the replaced slot's read-modify-write ends as the word advances.
// A full output register that is not taken stalls the work stage in place.
// Reset (arst_n low, asynchronous): empty history, level green, counters
//   zero, target 16667 us, level automatic. The ring RAM is not cleared.
`include "frame_time_budget_governor_macros.svh"

module frame_time_budget_governor #(
	parameter int RING_DEPTH     = ftbg_pkg::RING_DEPTH_DEF,
	parameter int RECOVER_FRAMES = ftbg_pkg::RECOVER_FRAMES_DEF,
	parameter int STALL_FRAMES   = ftbg_pkg::STALL_FRAMES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_we,
	input  logic [ftbg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ftbg_pkg::TARGET_W-1:0]      cfg_data,
	// input words
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ftbg_pkg::KIND_W-1:0]        kind,
	input  logic [ftbg_pkg::TIME_W-1:0]        time_us,
	input  logic                               pending_work,
	input  logic [ftbg_pkg::WEIGHT_W-1:0]      task_weight,
	// result words
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ftbg_pkg::LEVEL_W-1:0]       level,
	output logic                               task_allowed,
	output logic                               watchdog_fired
);

	localparam int SLOT_W = $clog2(RING_DEPTH);

	// config registers
	logic [ftbg_pkg::TARGET_W-1:0] target_q;
	logic [ftbg_pkg::LEVEL_W-1:0]  forced_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= ftbg_pkg::TARGET_RESET;
			forced_q <= ftbg_pkg::LVL_AUTO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ftbg_pkg::REG_TARGET: target_q <= cfg_data;
				ftbg_pkg::REG_FORCED: forced_q <= cfg_data[ftbg_pkg::LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// work stage: the accepted word waits here for its ring read data
	ftbg_pkg::item_t   item_s1;
	logic              s1_valid_q;
	logic              s1_adv;
	logic              in_fire;

	// output register
	ftbg_pkg::result_t res_q;
	logic              out_valid_q;
	ftbg_pkg::result_t res_d;

	// ring port wiring
	logic [SLOT_W-1:0]             rd_addr, wr_addr;
	logic                          wr_en, ring_we;
	logic [ftbg_pkg::TIME_W-1:0]   wr_data, old_time;

	// stage advances when the output register is empty or being drained
	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_fire  = in_valid && in_ready;
	assign ring_we  = wr_en && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.kind         <= kind;
			item_s1.time_us      <= time_us;
			item_s1.pending_work <= pending_work;
			item_s1.task_weight  <= task_weight;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_d;
		end
	end

	// the read is only issued on accept, so a stalled word keeps its data
	ftbg_ring #(
		.DEPTH(RING_DEPTH),
		.WIDTH(ftbg_pkg::TIME_W)
	) u_ring (
		.clk    (clk),
		.wr_en  (ring_we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (in_fire),
		.rd_addr(rd_addr),
		.rd_data(old_time)
	);

	ftbg_ctrl #(
		.RING_DEPTH    (RING_DEPTH),
		.RECOVER_FRAMES(RECOVER_FRAMES),
		.STALL_FRAMES  (STALL_FRAMES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (s1_adv),
		.item           (item_s1),
		.old_time       (old_time),
		.target_frame_us(target_q),
		.forced_level   (forced_q),
		.rd_addr        (rd_addr),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data),
		.result         (res_d)
	);

	assign out_valid      = out_valid_q;
	assign level          = res_q.level;
	assign task_allowed   = res_q.task_allowed;
	assign watchdog_fired = res_q.watchdog_fired;

	`FTBG_ASSERT_NOW(a_ring_no_clash, in_fire && ring_we, rd_addr != wr_addr, "ring read and write hit the same slot")
	`FTBG_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(item_s1), "stalled word lost from work stage")
	`FTBG_ASSERT_NEXT(a_result_lands, s1_adv, out_valid_q, "finished word not in output register")

endmodule
